>>> rtl/collective_barrier_table_macros.svh
// ----------------------------------------------------------------------------
// collective barrier table assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef COLLECTIVE_BARRIER_TABLE_MACROS_SVH
`define COLLECTIVE_BARRIER_TABLE_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define BCT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication with its consequent checked after the given delay
`define BCT_ASSERT_LATER(label, ante, dly, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |-> ##dly (cons)) else $error(msg);

`endif

>>> rtl/bct_pkg.sv
// ----------------------------------------------------------------------------
// bct_pkg
// shared types, codes and defaults of the collective barrier table
// ----------------------------------------------------------------------------
package bct_pkg;

   // default sizing, handed to the top level parameters
   localparam int SLOTS_DEF     = 16;
   localparam int MAX_GROUP_DEF = 64;
   localparam int KEY_BITS_DEF  = 32;

   // fixed field widths
   localparam int OP_W    = 2;
   localparam int KEY_W   = 32;
   localparam int PHASE_W = 16;
   localparam int RANK_W  = 6;
   localparam int GS_W    = 7;
   localparam int TREE_W  = 16;
   localparam int ST_W    = 3;
   localparam int DROP_W  = 5;
   localparam int CFG_W   = 5;

   // a rank field can name at most this many participants
   localparam int RANK_SPAN = 64;

   localparam logic [CFG_W-1:0]  MAX_ACTIVE_RST = 5'd16;
   localparam logic [DROP_W-1:0] DROP_SAT       = 5'd31;

   // opcodes
   localparam logic [OP_W-1:0] OP_ARRIVE = 2'd0;
   localparam logic [OP_W-1:0] OP_DEPART = 2'd1;
   localparam logic [OP_W-1:0] OP_ABORT  = 2'd2;
   localparam logic [OP_W-1:0] OP_RESET  = 2'd3;

   // status codes
   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_BAD      = 3'd1;
   localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
   localparam logic [ST_W-1:0] ST_SIZE     = 3'd3;
   localparam logic [ST_W-1:0] ST_TREE     = 3'd4;
   localparam logic [ST_W-1:0] ST_DUP      = 3'd5;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd6;
   localparam logic [ST_W-1:0] ST_NOTREL   = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]    opcode;
      logic [KEY_W-1:0]   coll_key;
      logic [PHASE_W-1:0] phase;
      logic [RANK_W-1:0]  rank;
      logic [GS_W-1:0]    grp_size;
      logic [TREE_W-1:0]  tree_id;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]   status;
      logic              release_res;
      logic              freed;
      logic [TREE_W-1:0] release_tree;
      logic [DROP_W-1:0] aborted_count;
   } rsp_type;

endpackage

>>> rtl/bct_req_stage.sv
// ----------------------------------------------------------------------------
// bct_req_stage
// command input register: holds one accepted command beat for the table
// ----------------------------------------------------------------------------
module bct_req_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  bct_pkg::req_type req,
   output logic             req_vld,
   output bct_pkg::req_type req_q
);
   import bct_pkg::*;

   logic    vld_ff;
   logic    vld_in;
   req_type req_ff;

   assign vld_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // payload only loads on an accepted beat
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req;
      end
   end

   assign req_vld = vld_ff;
   assign req_q   = req_ff;

endmodule

>>> rtl/bct_slot_table.sv
// ----------------------------------------------------------------------------
// bct_slot_table
// barrier entry storage, parallel key match and single-pass entry update
// ----------------------------------------------------------------------------
module bct_slot_table #(
   parameter int SLOTS     = bct_pkg::SLOTS_DEF,
   parameter int MAX_GROUP = bct_pkg::MAX_GROUP_DEF,
   parameter int KEY_BITS  = bct_pkg::KEY_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_vld,
   input  bct_pkg::req_type          req,
   input  logic                      csr_wr_en,
   input  logic [bct_pkg::CFG_W-1:0] csr_wr_data,
   output bct_pkg::rsp_type          rsp
);
   import bct_pkg::*;

   localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW   = $clog2(SLOTS + 1);
   localparam int KW   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
   localparam int MAPW = (MAX_GROUP < RANK_SPAN) ? MAX_GROUP : RANK_SPAN;

   // control state
   logic [SLOTS-1:0] valid_ff;
   logic [SLOTS-1:0] valid_in;
   logic [CW-1:0]    cnt_ff;
   logic [CW-1:0]    cnt_in;
   logic [CFG_W-1:0] max_ff;
   logic [CFG_W-1:0] max_in;

   // entry payload, written on allocate / join / depart
   logic [KW-1:0]     key_ff   [SLOTS];
   logic [PHASE_W-1:0] phase_ff [SLOTS];
   logic [GS_W-1:0]   exp_ff   [SLOTS];
   logic [MAPW-1:0]   map_ff   [SLOTS];
   logic [GS_W-1:0]   arr_ff   [SLOTS];
   logic [GS_W-1:0]   dep_ff   [SLOTS];
   logic [TREE_W-1:0] tree_ff  [SLOTS];

   logic [SLOTS-1:0]  hit;
   logic [SLOTS-1:0]  key_hit;
   logic [SLOTS-1:0]  drop;
   logic              found;
   logic              free_found;
   logic [IW-1:0]     hit_idx;
   logic [IW-1:0]     free_idx;
   logic [GS_W-1:0]   h_exp;
   logic [GS_W-1:0]   h_arr;
   logic [GS_W-1:0]   h_dep;
   logic [MAPW-1:0]   h_map;
   logic [TREE_W-1:0] h_tree;
   logic [GS_W-1:0]   arr_nxt;
   logic [GS_W-1:0]   dep_nxt;
   logic [MAPW-1:0]   rank_bit;
   logic              arg_bad;
   logic              do_alloc;
   logic              do_join;
   logic              do_depart;
   logic              do_free;
   logic [CW-1:0]     drop_cnt;

   // match lanes and lowest-index encoders
   always_comb begin
      found      = 1'b0;
      free_found = 1'b0;
      hit_idx    = '0;
      free_idx   = '0;
      for (int i = 0; i < SLOTS; i++) begin
         key_hit[i] = valid_ff[i] && (key_ff[i] == req.coll_key[KW-1:0]);
         hit[i]     = key_hit[i] && (phase_ff[i] == req.phase);
      end
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            found   = 1'b1;
            hit_idx = IW'(i);
         end
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IW'(i);
         end
      end
   end

   assign h_exp  = exp_ff[hit_idx];
   assign h_arr  = arr_ff[hit_idx];
   assign h_dep  = dep_ff[hit_idx];
   assign h_map  = map_ff[hit_idx];
   assign h_tree = tree_ff[hit_idx];

   assign arr_nxt  = h_arr + GS_W'(1);
   assign dep_nxt  = h_dep + GS_W'(1);
   assign rank_bit = MAPW'(1) << req.rank;
   assign arg_bad  = (req.grp_size == '0)
                  || (32'(req.grp_size) > 32'(MAX_GROUP))
                  || ({1'b0, req.rank} >= req.grp_size);

   // op decode and result
   always_comb begin
      rsp       = '0;
      do_alloc  = 1'b0;
      do_join   = 1'b0;
      do_depart = 1'b0;
      do_free   = 1'b0;
      drop      = '0;
      drop_cnt  = '0;
      case (req.opcode) inside
         OP_ARRIVE: begin
            if (arg_bad) begin
               rsp.status = ST_BAD;
            end else if (!found) begin
               if ((32'(cnt_ff) >= 32'(max_ff)) || !free_found) begin
                  rsp.status = ST_FULL;
               end else begin
                  do_alloc        = 1'b1;
                  rsp.release_res = (req.grp_size == GS_W'(1));
               end
            end else if (h_exp != req.grp_size) begin
               rsp.status = ST_SIZE;
            end else if (h_tree != req.tree_id) begin
               rsp.status = ST_TREE;
            end else if (|(h_map & rank_bit)) begin
               rsp.status = ST_DUP;
            end else begin
               do_join         = 1'b1;
               rsp.release_res = (arr_nxt == h_exp);
            end
         end
         OP_DEPART: begin
            if (!found) begin
               rsp.status = ST_NOTFOUND;
            end else if (h_arr != h_exp) begin
               rsp.status = ST_NOTREL;
            end else begin
               do_depart = 1'b1;
               if (dep_nxt >= h_exp) begin
                  do_free          = 1'b1;
                  rsp.freed        = 1'b1;
                  rsp.release_tree = h_tree;
               end
            end
         end
         OP_ABORT, OP_RESET: begin
            drop = (req.opcode == OP_RESET) ? valid_ff : key_hit;
            for (int i = 0; i < SLOTS; i++) begin
               drop_cnt = drop_cnt + CW'(drop[i]);
            end
            rsp.aborted_count = (32'(drop_cnt) > 32'(DROP_SAT)) ? DROP_SAT
                                                               : DROP_W'(drop_cnt);
         end
         default: begin
            rsp = '0;
         end
      endcase
   end

   // next control state
   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      if (req_vld) begin
         if (do_alloc) begin
            valid_in[free_idx] = 1'b1;
         end
         if (do_free) begin
            valid_in[hit_idx] = 1'b0;
         end
         valid_in = valid_in & ~drop;
         cnt_in   = cnt_ff + CW'(do_alloc) - CW'(do_free) - drop_cnt;
      end
   end

   // capacity limit only moves while the table is empty; zero is ignored
   assign max_in = (csr_wr_en && (csr_wr_data != '0) && (cnt_ff == '0)) ? csr_wr_data
                                                                         : max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cnt_ff   <= '0;
         max_ff   <= MAX_ACTIVE_RST;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
         max_ff   <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_vld && do_alloc) begin
         key_ff[free_idx]   <= req.coll_key[KW-1:0];
         phase_ff[free_idx] <= req.phase;
         exp_ff[free_idx]   <= req.grp_size;
         tree_ff[free_idx]  <= req.tree_id;
         map_ff[free_idx]   <= rank_bit;
         arr_ff[free_idx]   <= GS_W'(1);
         dep_ff[free_idx]   <= '0;
      end
      if (req_vld && do_join) begin
         map_ff[hit_idx] <= h_map | rank_bit;
         arr_ff[hit_idx] <= arr_nxt;
      end
      if (req_vld && do_depart) begin
         dep_ff[hit_idx] <= dep_nxt;
      end
   end

endmodule

>>> rtl/bct_rsp_stage.sv
// ----------------------------------------------------------------------------
// bct_rsp_stage
// result register: presents each response beat for one cycle with a strobe
// ----------------------------------------------------------------------------
module bct_rsp_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             rsp_vld,
   input  bct_pkg::rsp_type rsp,
   output logic             rsp_strobe,
   output bct_pkg::rsp_type rsp_q
);
   import bct_pkg::*;

   logic    vld_ff;
   logic    vld_in;
   rsp_type rsp_ff;

   assign vld_in = rsp_vld;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_vld) begin
         rsp_ff <= rsp;
      end
   end

   assign rsp_strobe = vld_ff;
   assign rsp_q      = rsp_ff;

endmodule

>>> rtl/collective_barrier_table.sv
// ----------------------------------------------------------------------------
// collective_barrier_table
// hardware barrier table keyed by collective key and phase
// ----------------------------------------------------------------------------
// command channel: drive start with the req_* fields; a command beat is taken
//   at every rising edge with start high and busy low. busy is tied low, so a
//   command can be issued in every cycle.
// response channel: one response beat per command, in command order. rsp_valid
//   is registered: the command register, then one table pass that updates the
//   entry and loads the result register, lie between the command and its beat.
// throughput: one command per cycle; each command sees the table state left
//   by the one before it, since that update commits on the preceding edge.
// the receiver cannot stall: a beat not sampled in its cycle is gone.
// config: csr_wr_en with csr_wr_data sets the active entry limit; a write of
//   zero, or one while any entry is live, is dropped. write only when no
//   command is in flight.
// reset (synchronous, high): all entries invalid, limit back to 16, no beat
//   pending. entry payload is not cleared, it is only read while valid.
// ----------------------------------------------------------------------------
module collective_barrier_table #(
   parameter int SLOTS     = bct_pkg::SLOTS_DEF,
   parameter int MAX_GROUP = bct_pkg::MAX_GROUP_DEF,
   parameter int KEY_BITS  = bct_pkg::KEY_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // command channel
   input  logic                        start,
   output logic                        busy,
   input  logic [bct_pkg::OP_W-1:0]    req_opcode,
   input  logic [bct_pkg::KEY_W-1:0]   req_coll_key,
   input  logic [bct_pkg::PHASE_W-1:0] req_phase,
   input  logic [bct_pkg::RANK_W-1:0]  req_rank,
   input  logic [bct_pkg::GS_W-1:0]    req_grp_size,
   input  logic [bct_pkg::TREE_W-1:0]  req_tree_id,
   // response channel
   output logic                        rsp_valid,
   output logic [bct_pkg::ST_W-1:0]    rsp_status,
   output logic                        rsp_release_res,
   output logic                        rsp_freed,
   output logic [bct_pkg::TREE_W-1:0]  rsp_release_tree,
   output logic [bct_pkg::DROP_W-1:0]  rsp_aborted_count,
   // config register
   input  logic                        csr_wr_en,
   input  logic [bct_pkg::CFG_W-1:0]   csr_wr_data
);
   import bct_pkg::*;

   logic    accept;
   req_type req_in;
   logic    req_vld;
   req_type req_q;
   rsp_type tbl_rsp;
   logic    rsp_strobe;
   rsp_type rsp_q;

   // every lookup finishes in one table pass, nothing ever holds off a command
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // pack the command beat
   always_comb begin
      req_in.opcode   = req_opcode;
      req_in.coll_key = req_coll_key;
      req_in.phase    = req_phase;
      req_in.rank     = req_rank;
      req_in.grp_size = req_grp_size;
      req_in.tree_id  = req_tree_id;
   end

   // stage 1: command register
   bct_req_stage u_req (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_in),
      .req_vld (req_vld),
      .req_q   (req_q)
   );

   // stage 2: match, check and entry update, result computed in the same pass
   bct_slot_table #(
      .SLOTS     (SLOTS),
      .MAX_GROUP (MAX_GROUP),
      .KEY_BITS  (KEY_BITS)
   ) u_tbl (
      .clock       (clock),
      .reset       (reset),
      .req_vld     (req_vld),
      .req         (req_q),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp         (tbl_rsp)
   );

   // result register, loaded on the edge that commits the table update
   bct_rsp_stage u_rsp (
      .clock      (clock),
      .reset      (reset),
      .rsp_vld    (req_vld),
      .rsp        (tbl_rsp),
      .rsp_strobe (rsp_strobe),
      .rsp_q      (rsp_q)
   );

   // unpack the response beat
   assign rsp_valid         = rsp_strobe;
   assign rsp_status        = rsp_q.status;
   assign rsp_release_res   = rsp_q.release_res;
   assign rsp_freed         = rsp_q.freed;
   assign rsp_release_tree  = rsp_q.release_tree;
   assign rsp_aborted_count = rsp_q.aborted_count;

endmodule

>>> rtl/bct_checker.sv
// ----------------------------------------------------------------------------
// bct_checker
// port-level checks on response timing and field consistency
// ----------------------------------------------------------------------------
`include "collective_barrier_table_macros.svh"

module bct_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic [bct_pkg::ST_W-1:0]    rsp_status,
   input logic                       rsp_release_res,
   input logic                       rsp_freed,
   input logic [bct_pkg::TREE_W-1:0]  rsp_release_tree,
   input logic [bct_pkg::DROP_W-1:0]  rsp_aborted_count
);
   import bct_pkg::*;

   // every command beat is followed by its response beat
   `BCT_ASSERT_LATER(a_rsp_follows_cmd, start && !busy, 2, rsp_valid, "response beat missing")

   // no response beat without an earlier command beat
   `BCT_ASSERT_NOW(a_no_spurious_rsp, rsp_valid, $past(start && !busy, 2), "unexpected response beat")

   // a freeing departure is a clean ok result with no release or drop count
   `BCT_ASSERT_NOW(a_free_is_ok, rsp_valid && rsp_freed, (rsp_status == ST_OK) && !rsp_release_res && (rsp_aborted_count == '0), "bad freed response")

   // error results carry no side information
   `BCT_ASSERT_NOW(a_err_clean, rsp_valid && (rsp_status != ST_OK), !rsp_release_res && !rsp_freed && (rsp_release_tree == '0) && (rsp_aborted_count == '0), "error response with data")

endmodule

bind collective_barrier_table bct_checker u_bct_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_release_res   (rsp_release_res),
   .rsp_freed         (rsp_freed),
   .rsp_release_tree  (rsp_release_tree),
   .rsp_aborted_count (rsp_aborted_count)
);

>>> test/collective_barrier_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// collective_barrier_table_tb
// self-checking bench for the barrier table: command beats come from a queue
// of pending commands, a shadow table predicts every response beat, and the
// response port is checked field by field in command order
// ----------------------------------------------------------------------------
module collective_barrier_table_tb;
   import bct_pkg::*;

   localparam int TBL_SLOTS   = SLOTS_DEF;
   localparam int GROUP_MAX   = MAX_GROUP_DEF;
   localparam int KEY_POOL_N  = 6;
   localparam int PHASE_ITEMS = 267;
   localparam int CYCLE_LIMIT = 300000;

   // planned barrier: one group walking through all its arrivals and departs
   typedef struct {
      logic [KEY_W-1:0]   key;
      logic [PHASE_W-1:0] phase;
      int                 size;
      logic [TREE_W-1:0]  tree;
      logic [RANK_SPAN-1:0] sent;
      int                 arrivals_left;
      int                 departs_left;
   } barrier_plan_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_opcode = '0;
   logic [KEY_W-1:0]    req_coll_key = '0;
   logic [PHASE_W-1:0]  req_phase = '0;
   logic [RANK_W-1:0]   req_rank = '0;
   logic [GS_W-1:0]     req_grp_size = '0;
   logic [TREE_W-1:0]   req_tree_id = '0;
   logic                rsp_valid;
   logic [ST_W-1:0]     rsp_status;
   logic                rsp_release_res;
   logic                rsp_freed;
   logic [TREE_W-1:0]   rsp_release_tree;
   logic [DROP_W-1:0]   rsp_aborted_count;
   logic                csr_wr_en = 1'b0;
   logic [CFG_W-1:0]    csr_wr_data = '0;

   // command beats waiting for the driver, responses waiting for the port
   req_type cmd_backlog[$];
   rsp_type pending_outcomes[$];
   barrier_plan_type plans[$];
   logic [KEY_W-1:0] key_pool [KEY_POOL_N];
   int plan_cap = 4;

   // shadow copy of the barrier table and its entry limit
   logic               tbl_valid    [TBL_SLOTS];
   logic [KEY_W-1:0]   tbl_key      [TBL_SLOTS];
   logic [PHASE_W-1:0] tbl_phase    [TBL_SLOTS];
   logic [GS_W-1:0]    tbl_expected [TBL_SLOTS];
   logic [RANK_SPAN-1:0] tbl_map    [TBL_SLOTS];
   logic [GS_W-1:0]    tbl_arrived  [TBL_SLOTS];
   logic [GS_W-1:0]    tbl_departed [TBL_SLOTS];
   logic [TREE_W-1:0]  tbl_tree     [TBL_SLOTS];
   logic [CFG_W-1:0]   tbl_limit;

   logic cmd_taken = 1'b0;
   int   mismatch_total = 0;
   int   cycle_count = 0;
   int   burst_left = 1;
   int   gap_left = 0;

   collective_barrier_table dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_coll_key      (req_coll_key),
      .req_phase         (req_phase),
      .req_rank          (req_rank),
      .req_grp_size      (req_grp_size),
      .req_tree_id       (req_tree_id),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_release_res   (rsp_release_res),
      .rsp_freed         (rsp_freed),
      .rsp_release_tree  (rsp_release_tree),
      .rsp_aborted_count (rsp_aborted_count),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // shadow table helpers
   // ---------------------------------------------------------------------
   function automatic int find_entry(logic [KEY_W-1:0] key, logic [PHASE_W-1:0] ph);
      for (int i = 0; i < TBL_SLOTS; i++)
         if (tbl_valid[i] && tbl_key[i] == key && tbl_phase[i] == ph) return i;
      return -1;
   endfunction

   function automatic int live_entries();
      int n;
      n = 0;
      for (int i = 0; i < TBL_SLOTS; i++)
         if (tbl_valid[i]) n++;
      return n;
   endfunction

   // applies one command to the shadow table and returns the response it owes
   function automatic rsp_type barrier_outcome(req_type c);
      rsp_type o;
      int s;
      int i;
      int dropped;
      o = '0;
      dropped = 0;
      case (c.opcode)
         OP_ARRIVE: begin
            if (c.grp_size == 0 || c.grp_size > GROUP_MAX ||
                {1'b0, c.rank} >= c.grp_size) begin
               o.status = ST_BAD;
            end else begin
               s = find_entry(c.coll_key, c.phase);
               if (s < 0) begin
                  if (live_entries() >= int'(tbl_limit)) begin
                     o.status = ST_FULL;
                  end else begin
                     // new barrier takes the lowest free entry
                     for (i = 0; i < TBL_SLOTS && tbl_valid[i]; i++) ;
                     if (i >= TBL_SLOTS) begin
                        o.status = ST_FULL;
                     end else begin
                        s = i;
                        tbl_valid[s]    = 1'b1;
                        tbl_key[s]      = c.coll_key;
                        tbl_phase[s]    = c.phase;
                        tbl_expected[s] = c.grp_size;
                        tbl_map[s]      = '0;
                        tbl_arrived[s]  = '0;
                        tbl_departed[s] = '0;
                        tbl_tree[s]     = c.tree_id;
                     end
                  end
               end else if (tbl_expected[s] != c.grp_size) begin
                  o.status = ST_SIZE;
                  s = -1;
               end else if (tbl_tree[s] != c.tree_id) begin
                  o.status = ST_TREE;
                  s = -1;
               end
               if (s >= 0) begin
                  if (tbl_map[s][c.rank]) begin
                     o.status = ST_DUP;
                  end else begin
                     tbl_map[s][c.rank] = 1'b1;
                     tbl_arrived[s] = tbl_arrived[s] + 1'b1;
                     if (tbl_arrived[s] == tbl_expected[s]) o.release_res = 1'b1;
                  end
               end
            end
         end
         OP_DEPART: begin
            s = find_entry(c.coll_key, c.phase);
            if (s < 0) begin
               o.status = ST_NOTFOUND;
            end else if (tbl_arrived[s] != tbl_expected[s]) begin
               o.status = ST_NOTREL;
            end else begin
               tbl_departed[s] = tbl_departed[s] + 1'b1;
               if (tbl_departed[s] >= tbl_expected[s]) begin
                  o.freed        = 1'b1;
                  o.release_tree = tbl_tree[s];
                  tbl_valid[s]   = 1'b0;
               end
            end
         end
         default: begin
            // abort drops every phase of one key, reset drops everything
            for (i = 0; i < TBL_SLOTS; i++) begin
               if (tbl_valid[i] && (c.opcode == OP_RESET || tbl_key[i] == c.coll_key)) begin
                  tbl_valid[i] = 1'b0;
                  dropped++;
               end
            end
            if (dropped > int'(DROP_SAT)) dropped = int'(DROP_SAT);
            o.aborted_count = DROP_W'(dropped);
         end
      endcase
      return o;
   endfunction

   task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_total++;
      end
   endtask

   // ---------------------------------------------------------------------
   // monitor: takes command beats into the shadow table, checks responses
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch_ports
      req_type seen;
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < TBL_SLOTS; i++) tbl_valid[i] = 1'b0;
         tbl_limit = MAX_ACTIVE_RST;
         cmd_taken <= 1'b0;
      end else begin
         // response beat: one cycle only, the receiver has no say
         if (rsp_valid === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
               $display("%0t ns: response beat with nothing expected, status %0h",
                        $time, rsp_status);
               mismatch_total++;
            end else begin
               want = pending_outcomes.pop_front();
               field_check("status", 32'(want.status), 32'(rsp_status));
               field_check("release_res", 32'(want.release_res), 32'(rsp_release_res));
               field_check("freed", 32'(want.freed), 32'(rsp_freed));
               field_check("release_tree", 32'(want.release_tree), 32'(rsp_release_tree));
               field_check("aborted_count", 32'(want.aborted_count),
                           32'(rsp_aborted_count));
            end
         end
         // command beat taken at this edge
         if (start && !busy) begin
            seen = {req_opcode, req_coll_key, req_phase, req_rank, req_grp_size,
                    req_tree_id};
            pending_outcomes = {pending_outcomes, barrier_outcome(seen)};
         end
         // limit write: zero, or any write with a live entry, is dropped
         if (csr_wr_en && csr_wr_data != '0 && live_entries() == 0) tbl_limit = csr_wr_data;
         cmd_taken <= start && !busy;
      end
   end

   // ---------------------------------------------------------------------
   // driver: bursts of command beats with random gaps, changes on falling edge
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : drive_cmds
      req_type cur;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || cmd_taken) begin
         if (gap_left > 0 || cmd_backlog.size() == 0) begin
            start <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end else begin
            cur = cmd_backlog.pop_front();
            start          <= 1'b1;
            req_opcode     <= cur.opcode;
            req_coll_key   <= cur.coll_key;
            req_phase      <= cur.phase;
            req_rank       <= cur.rank;
            req_grp_size   <= cur.grp_size;
            req_tree_id    <= cur.tree_id;
            if (burst_left <= 1) begin
               // long unbroken stretches now and then, otherwise short bursts
               burst_left <= ($urandom_range(9) < 3) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
               gap_left   <= ($urandom_range(9) < 4) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   function automatic req_type make_cmd(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                        logic [PHASE_W-1:0] ph, logic [RANK_W-1:0] rk,
                                        logic [GS_W-1:0] gs, logic [TREE_W-1:0] tr);
      req_type c;
      c.opcode   = op;
      c.coll_key = key;
      c.phase    = ph;
      c.rank     = rk;
      c.grp_size = gs;
      c.tree_id  = tr;
      return c;
   endfunction

   // append one command beat to the driver backlog
   function automatic void enqueue_cmd(req_type c);
      cmd_backlog = {cmd_backlog, c};
   endfunction

   // mostly well-formed barrier traffic, the rest broken or stray commands
   function automatic req_type next_cmd();
      barrier_plan_type p;
      req_type c;
      int i, r, roll, tries;
      logic clash;
      roll = $urandom_range(99);
      if (plans.size() == 0 || (plans.size() < plan_cap && roll < 20)) begin
         tries = 0;
         do begin
            p.key = key_pool[$urandom_range(KEY_POOL_N - 1)];
            r = $urandom_range(99);
            p.phase = (r < 70) ? PHASE_W'($urandom_range(3)) :
                      (r < 85) ? '1 : PHASE_W'($urandom);
            clash = 1'b0;
            foreach (plans[j])
               if (plans[j].key == p.key && plans[j].phase == p.phase) clash = 1'b1;
            tries++;
         end while (clash && tries < 8);
         // small groups mostly, a few wide ones up to the full rank span
         r = $urandom_range(99);
         if (r < 50)      p.size = $urandom_range(1, 3);
         else if (r < 88) p.size = $urandom_range(4, 8);
         else if (r < 98) p.size = $urandom_range(9, 32);
         else             p.size = $urandom_range(33, GROUP_MAX);
         p.tree = ($urandom_range(9) < 3) ? '0 : TREE_W'($urandom);
         p.sent = '0;
         p.arrivals_left = p.size;
         p.departs_left  = p.size;
         plans = {plans, p};
      end
      i = $urandom_range(plans.size() - 1);
      p = plans[i];
      c = make_cmd(OP_ARRIVE, p.key, p.phase, '0, GS_W'(p.size), p.tree);
      roll = $urandom_range(99);
      if (roll < 72) begin
         // next step of the group: a fresh rank, or a depart once all are in
         if (p.arrivals_left > 0) begin
            r = $urandom_range(p.size - 1);
            while (p.sent[r]) r = (r + 1) % p.size;
            p.sent[r] = 1'b1;
            p.arrivals_left--;
            c.rank = RANK_W'(r);
         end else begin
            c.opcode = OP_DEPART;
            p.departs_left--;
         end
         if (p.departs_left == 0) plans.delete(i);
         else plans[i] = p;
      end else if (roll < 77) begin
         // a rank that has already arrived, or the top rank if none has
         for (r = 0; r < p.size - 1 && !p.sent[r]; r++) ;
         c.rank = RANK_W'(r);
      end else if (roll < 81) begin
         c.grp_size = GS_W'((p.size % GROUP_MAX) + 1);
      end else if (roll < 85) begin
         c.tree_id = p.tree ^ TREE_W'($urandom_range(1, 65535));
      end else if (roll < 88) begin
         // group size zero, too large, or rank outside the group
         r = $urandom_range(2);
         if (r == 0) begin
            c.grp_size = '0;
            c.rank = RANK_W'($urandom);
         end else if (r == 1) begin
            c.grp_size = GS_W'($urandom_range(GROUP_MAX + 1, 127));
            c.rank = RANK_W'($urandom);
         end else begin
            c.grp_size = GS_W'($urandom_range(1, RANK_SPAN - 1));
            c.rank = RANK_W'($urandom_range(int'(c.grp_size), RANK_SPAN - 1));
         end
      end else if (roll < 91) begin
         // early depart, or a depart nobody arrived for
         c.opcode = OP_DEPART;
         if (p.arrivals_left == 0) c.coll_key = KEY_W'($urandom);
      end else if (roll < 94) begin
         c = make_cmd(OP_W'($urandom_range(1)), KEY_W'($urandom), PHASE_W'($urandom),
                      RANK_W'($urandom), GS_W'($urandom_range(127)), TREE_W'($urandom));
      end else if (roll < 97) begin
         c.opcode = OP_ABORT;
         if ($urandom_range(1) == 0) c.coll_key = key_pool[$urandom_range(KEY_POOL_N - 1)];
         for (int j = plans.size() - 1; j >= 0; j--)
            if (plans[j].key == c.coll_key) plans.delete(j);
      end else begin
         c.opcode = OP_RESET;
         plans.delete();
      end
      return c;
   endfunction

   // block is idle: nothing queued, nothing on the port, nothing owed
   task automatic wait_idle();
      do @(posedge clock);
      while (cmd_backlog.size() != 0 || start || pending_outcomes.size() != 0);
   endtask

   task automatic write_limit(logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus
      logic [CFG_W-1:0] limit_steps [6];
      int eff_limit;
      limit_steps = '{5'd31, 5'd0, 5'd1, 5'd3, 5'd16, 5'd8};
      eff_limit = 16;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // bad arrivals: empty group, oversize groups, rank past the group
      enqueue_cmd(make_cmd(OP_ARRIVE, 32'd1, 16'd0, 6'd0, 7'd0, 16'd0));
      enqueue_cmd(make_cmd(OP_ARRIVE, 32'd1, 16'd0, 6'd0, 7'd65, 16'd0));
      enqueue_cmd(make_cmd(OP_ARRIVE, 32'd1, 16'd0, 6'd63, 7'd127, 16'd0));
      enqueue_cmd(make_cmd(OP_ARRIVE, 32'd1, 16'd0, 6'd5, 7'd5, 16'd0));
      // depart of an unknown barrier
      enqueue_cmd(make_cmd(OP_DEPART, '1, 16'd0, 6'd0, 7'd1, 16'd0));
      // single-rank group releases at once and still departs
      enqueue_cmd(make_cmd(OP_ARRIVE, '1, '1, 6'd0, 7'd1, '1));
      enqueue_cmd(make_cmd(OP_DEPART, '1, '1, 6'd0, 7'd1, '1));
      // two-rank group with duplicate, size, tree and early-depart rejections on the way
      enqueue_cmd(make_cmd(OP_ARRIVE, 32'd0, 16'd0, 6'd1, 7'd2, 16'd0));
      enqueue_cmd(make_cmd(OP_ARRIVE, 32'd0, 16'd0, 6'd1, 7'd2, 16'd0));
      enqueue_cmd(make_cmd(OP_ARRIVE, 32'd0, 16'd0, 6'd0, 7'd3, 16'd0));
      enqueue_cmd(make_cmd(OP_ARRIVE, 32'd0, 16'd0, 6'd0, 7'd2, 16'd7));
      enqueue_cmd(make_cmd(OP_DEPART, 32'd0, 16'd0, 6'd0, 7'd2, 16'd0));
      enqueue_cmd(make_cmd(OP_ARRIVE, 32'd0, 16'd0, 6'd0, 7'd2, 16'd0));
      enqueue_cmd(make_cmd(OP_DEPART, 32'd0, 16'd0, 6'd0, 7'd2, 16'd0));
      enqueue_cmd(make_cmd(OP_DEPART, 32'd0, 16'd0, 6'd0, 7'd2, 16'd0));
      // abort takes every phase of one key only
      enqueue_cmd(make_cmd(OP_ARRIVE, 32'd5, 16'd1, 6'd0, 7'd3, 16'd9));
      enqueue_cmd(make_cmd(OP_ARRIVE, 32'd5, 16'd2, 6'd0, 7'd3, 16'd9));
      enqueue_cmd(make_cmd(OP_ARRIVE, 32'd6, 16'd1, 6'd0, 7'd3, 16'd9));
      enqueue_cmd(make_cmd(OP_ABORT, 32'd5, 16'd0, 6'd0, 7'd0, 16'd0));
      enqueue_cmd(make_cmd(OP_DEPART, 32'd5, 16'd1, 6'd0, 7'd3, 16'd9));
      // top rank of a full-width group, then reset all twice
      enqueue_cmd(make_cmd(OP_ARRIVE, 32'h8000_0001, 16'h1234, 6'd63, 7'd64,
                           16'hABCD));
      enqueue_cmd(make_cmd(OP_RESET, 32'd0, 16'd0, 6'd0, 7'd0, 16'd0));
      enqueue_cmd(make_cmd(OP_RESET, 32'd0, 16'd0, 6'd0, 7'd0, 16'd0));
      wait_idle();

      // limit write with a live entry must be dropped
      enqueue_cmd(make_cmd(OP_ARRIVE, 32'h77, 16'd0, 6'd0, 7'd2, 16'd0));
      wait_idle();
      write_limit(5'd1);
      enqueue_cmd(make_cmd(OP_RESET, 32'd0, 16'd0, 6'd0, 7'd0, 16'd0));
      wait_idle();

      // random phases, one per limit write (a zero write keeps the limit before it), each ending empty
      foreach (limit_steps[k]) begin
         write_limit(limit_steps[k]);
         if (limit_steps[k] != '0) eff_limit = int'(limit_steps[k]);
         plan_cap = (eff_limit + 2 > 20) ? 20 : eff_limit + 2;
         key_pool[0] = '0;
         key_pool[1] = '1;
         for (int j = 2; j < KEY_POOL_N; j++) key_pool[j] = KEY_W'($urandom);
         for (int n = 0; n < PHASE_ITEMS; n++) enqueue_cmd(next_cmd());
         enqueue_cmd(make_cmd(OP_RESET, 32'd0, 16'd0, 6'd0, 7'd0, 16'd0));
         plans.delete();
         wait_idle();
      end

      // leave some slack for stray response beats
      repeat (8) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/bct_pkg.sv
rtl/bct_req_stage.sv
rtl/bct_slot_table.sv
rtl/bct_rsp_stage.sv
rtl/collective_barrier_table.sv
rtl/bct_checker.sv
test/collective_barrier_table_tb.sv
